// ----- sv/sliding_window_rate_monitor_assert.svh -----
// ----------------------------------------------------------------------------
// Sliding window rate monitor: assertion macros
// Concurrent assertion wrappers clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_MONITOR_ASSERT_SVH
`define SLIDING_WINDOW_RATE_MONITOR_ASSERT_SVH

// Same-cycle implication.
`define SWRM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/swrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window rate monitor package
// Shared constants, register map, status codes and arithmetic unit opcodes.
// ----------------------------------------------------------------------------
package swrm_pkg;

    localparam int RING_DEPTH_DEFAULT = 256;
    localparam int TIME_BITS_DEFAULT  = 32;

    localparam int FIELD_W = 32;
    localparam int BYTES_W = 24;
    localparam int PUBS_W  = 8;
    localparam int THR_W   = 16;
    localparam int ADDR_W  = 4;

    localparam logic [FIELD_W-1:0] WINDOW_RESET = 32'd1000000;
    localparam logic [FIELD_W-1:0] STALE_RESET  = 32'd1000000;
    localparam logic [THR_W-1:0]   SLOW_RESET   = 16'd0;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_WINDOW = 2'd0;
    localparam t_reg_idx REG_STALE  = 2'd1;
    localparam t_reg_idx REG_SLOW   = 2'd2;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_REPORT  = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_SLOW  = 2'd1;
    localparam t_status ST_STALE = 2'd2;
    localparam t_status ST_NOPUB = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ----- sv/swrm_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared add / subtract unit
// One adder used for byte sums, modular ages and every threshold compare.
// ----------------------------------------------------------------------------
module swrm_alu #(
    parameter int W = 32
) (
    input  swrm_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W-1:0]      o_y,
    output logic              o_lt
);

    logic [W:0] ext;

    always_comb begin
        case (i_op)
            swrm_pkg::ALU_SUB: ext = {1'b0, i_a} - {1'b0, i_b};
            default:           ext = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end

    assign o_y = ext[W-1:0];
    // borrow out of the subtract: a below b
    assign o_lt = (i_op == swrm_pkg::ALU_SUB) && ext[W];

endmodule

// ----- sv/swrm_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample ring store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module swrm_ring #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 56
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sliding_window_rate_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window rate monitor
// Keeps a ring of recent message samples and reports window health on request.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low; busy stays high until the
// item is done. An arrival appends its sample, first dropping the oldest sample
// when the ring is full. A report ages the oldest sample against the window and
// drops it while it has left, then computes the age since the last arrival, the
// stale test and the slow test. Every step goes through the one shared
// add/subtract unit. A report's result appears on the o_ ports, with o_done high
// for a single cycle, in the first cycle in which busy is low again; there is no
// back-pressure, so capture it then. Arrivals give no result. The sample ring is
// not cleared after reset and needs no clearing pass: only entries written by
// arrivals are ever read.
// ----------------------------------------------------------------------------
module sliding_window_rate_monitor #(
    parameter int RING_DEPTH = swrm_pkg::RING_DEPTH_DEFAULT,
    parameter int TIME_BITS  = swrm_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [swrm_pkg::ADDR_W-1:0]          paddr,
    input  logic [swrm_pkg::FIELD_W-1:0]         pwdata,
    output logic [swrm_pkg::FIELD_W-1:0]         prdata,
    output logic                                 pready,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_req_type,
    input  logic [swrm_pkg::FIELD_W-1:0]         i_time_now,
    input  logic [swrm_pkg::BYTES_W-1:0]         i_msg_bytes,
    input  logic [swrm_pkg::PUBS_W-1:0]          i_publisher_count,
    output logic                                 o_done,
    output logic [$clog2(RING_DEPTH+1)-1:0]      o_window_count,
    output logic [swrm_pkg::FIELD_W-1:0]         o_win_byte_sum,
    output logic [swrm_pkg::FIELD_W-1:0]         o_total_count,
    output logic [swrm_pkg::FIELD_W-1:0]         o_age_ticks,
    output logic                                 o_never_seen,
    output swrm_pkg::t_status                    o_health_status
);

    localparam int HW  = $clog2(RING_DEPTH);
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int TW  = TIME_BITS;
    localparam int BW  = swrm_pkg::BYTES_W;
    localparam int SW  = BW + FW;
    localparam int AW0 = (TW > SW) ? TW : SW;
    localparam int AW  = (AW0 > swrm_pkg::FIELD_W) ? AW0 : swrm_pkg::FIELD_W;
    localparam int MW  = TW + BW;

    localparam logic [HW:0]   DEPTH_X = (HW + 1)'(RING_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(RING_DEPTH);
    localparam logic [HW-1:0] LAST_IX = HW'(RING_DEPTH - 1);
    localparam logic [AW-1:0] SAT_32  = AW'({swrm_pkg::FIELD_W{1'b1}});

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ARR_DROP = 4'd1;
    localparam logic [3:0] S_ARR_ADD  = 4'd2;
    localparam logic [3:0] S_PR_AGE   = 4'd3;
    localparam logic [3:0] S_PR_CMP   = 4'd4;
    localparam logic [3:0] S_PR_DROP  = 4'd5;
    localparam logic [3:0] S_RP_AGE   = 4'd6;
    localparam logic [3:0] S_RP_STALE = 4'd7;
    localparam logic [3:0] S_RP_FIN   = 4'd8;

    // control state
    logic [3:0]                   r_state, n_state;
    logic [HW-1:0]                r_head, n_head;
    logic [FW-1:0]                r_fill, n_fill;
    logic [SW-1:0]                r_sum, n_sum;
    logic [swrm_pkg::FIELD_W-1:0] r_total, n_total;
    logic [TW-1:0]                r_last, n_last;
    logic                         r_done, n_done;
    logic [swrm_pkg::FIELD_W-1:0] r_window;
    logic [swrm_pkg::FIELD_W-1:0] r_stale_ticks;
    logic [swrm_pkg::THR_W-1:0]   r_thr;

    // item payload and scratch
    logic [TW-1:0]                r_now;
    logic [BW-1:0]                r_bytes;
    logic [swrm_pkg::PUBS_W-1:0]  r_pubs;
    logic [TW-1:0]                r_age;
    logic                         r_stale;

    // result registers
    logic [FW-1:0]                r_out_count;
    logic [swrm_pkg::FIELD_W-1:0] r_out_bytes;
    logic [swrm_pkg::FIELD_W-1:0] r_out_total;
    logic [swrm_pkg::FIELD_W-1:0] r_out_age;
    logic                         r_out_never;
    swrm_pkg::t_status            r_out_status;

    swrm_pkg::t_alu_op            alu_op;
    logic [AW-1:0]                alu_a;
    logic [AW-1:0]                alu_b;
    logic [AW-1:0]                alu_y;
    logic                         alu_lt;

    logic                         accept;
    logic                         never;
    logic [HW:0]                  slot_sum;
    logic [HW-1:0]                slot;
    logic [HW-1:0]                head_next;
    logic [MW-1:0]                rd_word;
    logic [TW-1:0]                rd_stamp;
    logic [BW-1:0]                rd_size;
    logic                         ring_we;
    swrm_pkg::t_status            status;
    logic                         cfg_wr;
    swrm_pkg::t_reg_idx           cfg_idx;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign never     = (r_total == '0);
    assign head_next = (r_head == LAST_IX) ? '0 : r_head + HW'(1);
    assign slot_sum  = (HW + 1)'(r_head) + (HW + 1)'(r_fill);
    assign slot      = (slot_sum >= DEPTH_X) ? HW'(slot_sum - DEPTH_X) : HW'(slot_sum);
    assign rd_stamp  = rd_word[MW-1:BW];
    assign rd_size   = rd_word[BW-1:0];
    assign ring_we   = (r_state == S_ARR_ADD);

    swrm_alu #(
        .W (AW)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y),
        .o_lt (alu_lt)
    );

    // read address follows the next head so the oldest sample is always ready
    swrm_ring #(
        .DEPTH (RING_DEPTH),
        .WIDTH (MW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (slot),
        .i_wdata ({r_now, r_bytes}),
        .i_raddr (n_head),
        .o_rdata (rd_word)
    );

    always_comb begin
        if (r_pubs == '0) begin
            status = swrm_pkg::ST_NOPUB;
        end else if (never || r_stale) begin
            status = swrm_pkg::ST_STALE;
        end else if (alu_lt) begin
            status = swrm_pkg::ST_SLOW;
        end else begin
            status = swrm_pkg::ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_fill  = r_fill;
        n_sum   = r_sum;
        n_total = r_total;
        n_last  = r_last;
        n_done  = 1'b0;
        alu_op  = swrm_pkg::ALU_ADD;
        alu_a   = '0;
        alu_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == swrm_pkg::REQ_ARRIVAL) begin
                        n_state = (r_fill == DEPTH_F) ? S_ARR_DROP : S_ARR_ADD;
                    end else begin
                        n_state = (r_fill != '0) ? S_PR_AGE : S_RP_AGE;
                    end
                end
            end
            S_ARR_DROP: begin
                // ring full: drop the oldest sample before appending
                alu_op  = swrm_pkg::ALU_SUB;
                alu_a   = AW'(r_sum);
                alu_b   = AW'(rd_size);
                n_sum   = SW'(alu_y);
                n_head  = head_next;
                n_fill  = r_fill - FW'(1);
                n_state = S_ARR_ADD;
            end
            S_ARR_ADD: begin
                alu_op  = swrm_pkg::ALU_ADD;
                alu_a   = AW'(r_sum);
                alu_b   = AW'(r_bytes);
                n_sum   = SW'(alu_y);
                n_fill  = r_fill + FW'(1);
                n_last  = r_now;
                n_total = (r_total == '1) ? r_total : r_total + 32'd1;
                n_state = S_IDLE;
            end
            S_PR_AGE: begin
                alu_op  = swrm_pkg::ALU_SUB;
                alu_a   = AW'(r_now);
                alu_b   = AW'(rd_stamp);
                n_state = S_PR_CMP;
            end
            S_PR_CMP: begin
                // window below age: sample has left the window
                alu_op  = swrm_pkg::ALU_SUB;
                alu_a   = AW'(r_window);
                alu_b   = AW'(r_age);
                n_state = alu_lt ? S_PR_DROP : S_RP_AGE;
            end
            S_PR_DROP: begin
                alu_op  = swrm_pkg::ALU_SUB;
                alu_a   = AW'(r_sum);
                alu_b   = AW'(rd_size);
                n_sum   = SW'(alu_y);
                n_head  = head_next;
                n_fill  = r_fill - FW'(1);
                n_state = (r_fill == FW'(1)) ? S_RP_AGE : S_PR_AGE;
            end
            S_RP_AGE: begin
                alu_op  = swrm_pkg::ALU_SUB;
                alu_a   = AW'(r_now);
                alu_b   = AW'(r_last);
                n_state = S_RP_STALE;
            end
            S_RP_STALE: begin
                alu_op  = swrm_pkg::ALU_SUB;
                alu_a   = AW'(r_stale_ticks);
                alu_b   = AW'(r_age);
                n_state = S_RP_FIN;
            end
            S_RP_FIN: begin
                // slow test: fill below threshold
                alu_op  = swrm_pkg::ALU_SUB;
                alu_a   = AW'(r_fill);
                alu_b   = AW'(r_thr);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_total <= '0;
            r_last  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_total <= n_total;
            r_last  <= n_last;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now   <= TW'(i_time_now);
            r_bytes <= i_msg_bytes;
            r_pubs  <= i_publisher_count;
        end
        if (r_state == S_PR_AGE) begin
            r_age <= TW'(alu_y);
        end
        if (r_state == S_RP_AGE) begin
            r_age <= never ? '0 : TW'(alu_y);
        end
        if (r_state == S_RP_STALE) begin
            r_stale <= alu_lt;
        end
        if (r_state == S_RP_FIN) begin
            r_out_count  <= r_fill;
            r_out_bytes  <= (AW'(r_sum) > SAT_32) ? '1 : swrm_pkg::FIELD_W'(r_sum);
            r_out_total  <= r_total;
            r_out_age    <= swrm_pkg::FIELD_W'(r_age);
            r_out_never  <= never;
            r_out_status <= status;
        end
    end

    // configuration port
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= swrm_pkg::WINDOW_RESET;
            r_stale_ticks <= swrm_pkg::STALE_RESET;
            r_thr         <= swrm_pkg::SLOW_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                swrm_pkg::REG_WINDOW: r_window      <= pwdata;
                swrm_pkg::REG_STALE:  r_stale_ticks <= pwdata;
                swrm_pkg::REG_SLOW:   r_thr         <= pwdata[swrm_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            swrm_pkg::REG_WINDOW: prdata = r_window;
            swrm_pkg::REG_STALE:  prdata = r_stale_ticks;
            swrm_pkg::REG_SLOW:   prdata = swrm_pkg::FIELD_W'(r_thr);
            default:              prdata = '0;
        endcase
    end

    assign o_done          = r_done;
    assign o_window_count  = r_out_count;
    assign o_win_byte_sum  = r_out_bytes;
    assign o_total_count   = r_out_total;
    assign o_age_ticks     = r_out_age;
    assign o_never_seen    = r_out_never;
    assign o_health_status = r_out_status;

endmodule

// ----- sv/swrm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window rate monitor port checker
// Watches the command and result ports of the monitor over time.
// ----------------------------------------------------------------------------
`include "sliding_window_rate_monitor_assert.svh"

module swrm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic                         o_never_seen,
    input logic [swrm_pkg::FIELD_W-1:0] o_age_ticks,
    input swrm_pkg::t_status            o_health_status
);

    `SWRM_ASSERT_SAME(a_done_when_idle, o_done, !busy, "result beat while busy")
    `SWRM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item left block idle")
    `SWRM_ASSERT_NEXT(a_done_single, o_done, !o_done, "result beats back to back")
    `SWRM_ASSERT_SAME(a_never_report, o_done && o_never_seen, (o_age_ticks == '0) && ((o_health_status == swrm_pkg::ST_STALE) || (o_health_status == swrm_pkg::ST_NOPUB)), "never seen report inconsistent")

endmodule

bind sliding_window_rate_monitor swrm_checker u_swrm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_never_seen    (o_never_seen),
    .o_age_ticks     (o_age_ticks),
    .o_health_status (o_health_status)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window rate monitor testbench
// Drives arrivals and health reports through the start/busy port and sets the
// window, stale and slow limits over APB. A behavioural copy of the sample
// ring predicts each report, and every o_done beat is compared field by field
// with the oldest prediction. Directed cases come first, then random traffic
// under several limit settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int                 SAMPLE_SLOTS = swrm_pkg::RING_DEPTH_DEFAULT;
    localparam swrm_pkg::t_reg_idx REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [8:0]        window_count;
        logic [31:0]       win_byte_sum;
        logic [31:0]       total_count;
        logic [31:0]       age_ticks;
        logic              never_seen;
        swrm_pkg::t_status health_status;
    } t_health_report;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [swrm_pkg::ADDR_W-1:0]   paddr;
    logic [swrm_pkg::FIELD_W-1:0]  pwdata;
    logic [swrm_pkg::FIELD_W-1:0]  prdata;
    logic                          pready;
    logic                          start;
    logic                          busy;
    logic                          i_req_type;
    logic [swrm_pkg::FIELD_W-1:0]  i_time_now;
    logic [swrm_pkg::BYTES_W-1:0]  i_msg_bytes;
    logic [swrm_pkg::PUBS_W-1:0]   i_publisher_count;
    logic                          o_done;
    logic [8:0]                    o_window_count;
    logic [swrm_pkg::FIELD_W-1:0]  o_win_byte_sum;
    logic [swrm_pkg::FIELD_W-1:0]  o_total_count;
    logic [swrm_pkg::FIELD_W-1:0]  o_age_ticks;
    logic                          o_never_seen;
    swrm_pkg::t_status             o_health_status;

    // Predictor state
    logic [31:0] sample_stamp [SAMPLE_SLOTS];
    logic [23:0] sample_size [SAMPLE_SLOTS];
    logic [7:0]  oldest_slot;
    int          held_count;
    logic [40:0] held_bytes;
    logic [31:0] arrivals_seen;
    logic [31:0] last_stamp;
    logic [31:0] window_len;
    logic [31:0] stale_len;
    logic [15:0] slow_floor;

    t_health_report pending_reports [$];
    int             mismatch_count;
    logic [31:0]    now_ticks;
    bit             quiet_sender;

    sliding_window_rate_monitor u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_time_now        (i_time_now),
        .i_msg_bytes       (i_msg_bytes),
        .i_publisher_count (i_publisher_count),
        .o_done            (o_done),
        .o_window_count    (o_window_count),
        .o_win_byte_sum    (o_win_byte_sum),
        .o_total_count     (o_total_count),
        .o_age_ticks       (o_age_ticks),
        .o_never_seen      (o_never_seen),
        .o_health_status   (o_health_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10000000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void drop_oldest_sample();
        if (held_count != 0) begin
            held_bytes  = held_bytes - sample_size[oldest_slot];
            oldest_slot = oldest_slot + 8'd1;
            held_count  = held_count - 1;
        end
    endfunction

    function automatic void record_arrival(input logic [31:0] t, input logic [23:0] nbytes);
        logic [7:0] slot;
        if (held_count >= SAMPLE_SLOTS)
            drop_oldest_sample();
        slot               = oldest_slot + 8'(held_count);
        sample_stamp[slot] = t;
        sample_size[slot]  = nbytes;
        held_count         = held_count + 1;
        held_bytes         = held_bytes + nbytes;
        last_stamp         = t;
        if (arrivals_seen != 32'hFFFF_FFFF)
            arrivals_seen = arrivals_seen + 32'd1;
    endfunction

    function automatic t_health_report predict_health(input logic [31:0] t,
                                                      input logic [7:0] pubs);
        t_health_report rep;
        logic [31:0]    sample_age;
        // Drop from the oldest end until a sample is inside the window
        while (held_count != 0) begin
            sample_age = t - sample_stamp[oldest_slot];
            if (sample_age > window_len)
                drop_oldest_sample();
            else
                break;
        end
        rep.never_seen = (arrivals_seen == 32'd0);
        rep.age_ticks  = rep.never_seen ? 32'd0 : t - last_stamp;
        if (pubs == 8'd0)
            rep.health_status = swrm_pkg::ST_NOPUB;
        else if (rep.never_seen || rep.age_ticks > stale_len)
            rep.health_status = swrm_pkg::ST_STALE;
        else if (held_count < int'(slow_floor))
            rep.health_status = swrm_pkg::ST_SLOW;
        else
            rep.health_status = swrm_pkg::ST_OK;
        rep.window_count = 9'(held_count);
        rep.win_byte_sum = (held_bytes > 41'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : held_bytes[31:0];
        rep.total_count  = arrivals_seen;
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_health_report exp_rep;
        if (i_rst_n && o_done) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result beat: window_count %0d total_count %0d",
                       o_window_count, o_total_count);
                mismatch_count++;
            end else begin
                exp_rep = pending_reports[0];
                pending_reports.delete(0);
                if (o_window_count !== exp_rep.window_count) begin
                    $error("window_count: expected %0d, got %0d",
                           exp_rep.window_count, o_window_count);
                    mismatch_count++;
                end
                if (o_win_byte_sum !== exp_rep.win_byte_sum) begin
                    $error("win_byte_sum: expected %0d, got %0d",
                           exp_rep.win_byte_sum, o_win_byte_sum);
                    mismatch_count++;
                end
                if (o_total_count !== exp_rep.total_count) begin
                    $error("total_count: expected %0d, got %0d",
                           exp_rep.total_count, o_total_count);
                    mismatch_count++;
                end
                if (o_age_ticks !== exp_rep.age_ticks) begin
                    $error("age_ticks: expected %0d, got %0d",
                           exp_rep.age_ticks, o_age_ticks);
                    mismatch_count++;
                end
                if (o_never_seen !== exp_rep.never_seen) begin
                    $error("never_seen: expected %0d, got %0d",
                           exp_rep.never_seen, o_never_seen);
                    mismatch_count++;
                end
                if (o_health_status !== exp_rep.health_status) begin
                    $error("health_status: expected %0d, got %0d",
                           exp_rep.health_status, o_health_status);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [31:0] t,
                             input logic [23:0] nbytes, input logic [7:0] pubs);
        start             <= 1'b1;
        i_req_type        <= kind;
        i_time_now        <= t;
        i_msg_bytes       <= nbytes;
        i_publisher_count <= pubs;
        do @(posedge i_clk); while (busy);
        if (kind == swrm_pkg::REQ_ARRIVAL)
            record_arrival(t, nbytes);
        else
            pending_reports = {pending_reports, predict_health(t, pubs)};
        if (!quiet_sender && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Hold until the block is idle and every report has come back
    task automatic wait_drained();
        do @(posedge i_clk); while (busy || pending_reports.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input swrm_pkg::t_reg_idx idx, input logic [31:0] value);
        start <= 1'b0;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            swrm_pkg::REG_WINDOW: window_len = value;
            swrm_pkg::REG_STALE:  stale_len  = value;
            swrm_pkg::REG_SLOW:   slow_floor = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [31:0] win, input logic [31:0] stale,
                              input logic [31:0] slow);
        write_register(swrm_pkg::REG_WINDOW, win);
        write_register(swrm_pkg::REG_STALE, stale);
        write_register(swrm_pkg::REG_SLOW, slow);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reports_before_arrival();
        send_item(swrm_pkg::REQ_REPORT, 32'd0, 24'd0, 8'd5);
        send_item(swrm_pkg::REQ_REPORT, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'd0);
    endtask

    task automatic test_wrap_and_boundaries();
        // Stamps straddle the time wrap
        send_item(swrm_pkg::REQ_ARRIVAL, 32'hFFFF_FFF0, 24'hFF_FFFF, 8'hFF);
        send_item(swrm_pkg::REQ_ARRIVAL, 32'hFFFF_FFFF, 24'd0, 8'd0);
        send_item(swrm_pkg::REQ_ARRIVAL, 32'h0000_0010, 24'd1, 8'd0);
        send_item(swrm_pkg::REQ_REPORT, 32'h0000_0020, 24'd0, 8'd255);
        send_item(swrm_pkg::REQ_REPORT, 32'h0000_0020, 24'd0, 8'd0);
        // Report time behind the last arrival
        send_item(swrm_pkg::REQ_REPORT, 32'h0000_0005, 24'd0, 8'd1);
        // Zero window keeps only samples stamped at the report time
        write_register(swrm_pkg::REG_WINDOW, 32'd0);
        send_item(swrm_pkg::REQ_ARRIVAL, 32'd100, 24'd7, 8'd0);
        send_item(swrm_pkg::REQ_ARRIVAL, 32'd100, 24'd9, 8'd0);
        send_item(swrm_pkg::REQ_REPORT, 32'd100, 24'd0, 8'd1);
        send_item(swrm_pkg::REQ_REPORT, 32'd101, 24'd0, 8'd1);
        // Age exactly at the stale limit, then one past it
        write_register(swrm_pkg::REG_STALE, 32'd5);
        send_item(swrm_pkg::REQ_ARRIVAL, 32'd200, 24'd3, 8'd0);
        send_item(swrm_pkg::REQ_REPORT, 32'd205, 24'd0, 8'd1);
        send_item(swrm_pkg::REQ_REPORT, 32'd206, 24'd0, 8'd1);
        write_register(swrm_pkg::REG_WINDOW, 32'hFFFF_FFFF);
        write_register(swrm_pkg::REG_SLOW, 32'd1);
        send_item(swrm_pkg::REQ_REPORT, 32'd206, 24'd0, 8'd1);
        write_register(swrm_pkg::REG_STALE, 32'hFFFF_FFFF);
        send_item(swrm_pkg::REQ_REPORT, 32'd206, 24'd0, 8'd1);
        send_item(swrm_pkg::REQ_ARRIVAL, 32'd207, 24'd4, 8'd0);
        send_item(swrm_pkg::REQ_REPORT, 32'd207, 24'd0, 8'd1);
    endtask

    task automatic test_register_writes();
        // Unmapped index must leave the limits alone
        write_register(REG_UNMAPPED, 32'd0);
        send_item(swrm_pkg::REQ_REPORT, 32'd300, 24'd0, 8'd1);
        // Upper bits of the slow threshold are dropped
        write_register(swrm_pkg::REG_SLOW, 32'hFFFF_0003);
        send_item(swrm_pkg::REQ_REPORT, 32'd300, 24'd0, 8'd1);
    endtask

    task automatic run_traffic(input int items, input int arrival_pct, input int max_step);
        int          pick;
        int          size_pick;
        logic [23:0] nbytes;
        logic [7:0]  pubs;
        for (int n = 0; n < items; n++) begin
            pick      = $urandom_range(0, 99);
            size_pick = $urandom_range(0, 9);
            if (size_pick < 2)
                nbytes = 24'hFF_FFFF;
            else if (size_pick == 2)
                nbytes = 24'd0;
            else
                nbytes = 24'($urandom);
            pubs = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            if (pick < 5) begin
                // Noise: any time, any kind
                send_item(1'($urandom), $urandom, 24'($urandom), 8'($urandom));
            end else begin
                if (pick < 8)
                    now_ticks = now_ticks + $urandom_range(0, 20 * max_step + 20);
                else
                    now_ticks = now_ticks + $urandom_range(0, max_step);
                if ($urandom_range(0, 99) < arrival_pct)
                    send_item(swrm_pkg::REQ_ARRIVAL, now_ticks, nbytes, 8'($urandom));
                else
                    send_item(swrm_pkg::REQ_REPORT, now_ticks, 24'($urandom), pubs);
            end
        end
    endtask

    task automatic test_mixed_traffic();
        set_limits(32'd1000, 32'd500, 32'd5);
        now_ticks = $urandom;
        run_traffic(450, 70, 100);

        // Endless window fills the ring past its depth; no idling here
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535);
        quiet_sender = 1'b1;
        run_traffic(500, 90, 50);
        quiet_sender = 1'b0;

        set_limits(32'd0, 32'd0, 32'd1);
        run_traffic(300, 60, 2);

        set_limits(32'd1, 32'd1, 32'd0);
        run_traffic(300, 60, 3);

        set_limits($urandom_range(1, 5000), $urandom_range(0, 3000), $urandom_range(0, 300));
        now_ticks = 32'hFFFF_F000;
        run_traffic(450, 75, 60);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        start             <= 1'b0;
        i_req_type        <= swrm_pkg::REQ_ARRIVAL;
        i_time_now        <= '0;
        i_msg_bytes       <= '0;
        i_publisher_count <= '0;
        oldest_slot    = '0;
        held_count     = 0;
        held_bytes     = '0;
        arrivals_seen  = '0;
        last_stamp     = '0;
        window_len     = swrm_pkg::WINDOW_RESET;
        stale_len      = swrm_pkg::STALE_RESET;
        slow_floor     = swrm_pkg::SLOW_RESET;
        mismatch_count = 0;
        quiet_sender   = 1'b0;
        now_ticks      = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reports_before_arrival();
        test_wrap_and_boundaries();
        test_register_writes();
        test_mixed_traffic();

        start <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
